### hdl/fvc_pkg.sv
// ----------------------------------------------------------------------------
// fvc_pkg
// types, codes and arithmetic helpers shared by the frustum cull blocks
// ----------------------------------------------------------------------------
package fvc_pkg;

  localparam int unsigned NumPlanes = 6;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CFG_LEFT   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_RIGHT  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TOP    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BOTTOM = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_NEAR   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_FAR    = 3'd5;

  localparam logic [CfgDataW-1:0] PlaneReset [NumPlanes] = '{
    64'h4000_0000_0000_0000, 64'hC000_0000_0000_0000, 64'h000C_0000_0000_0000,
    64'h0004_0000_0000_0000, 64'h0000_0040_0000_0000, 64'h0000_00C0_0000_0000
  };

  typedef enum logic [1:0] {
    FUNC_POINT        = 2'd0,
    FUNC_SPHERE_HIT   = 2'd1,
    FUNC_SPHERE_CLASS = 2'd2,
    FUNC_BOX          = 2'd3
  } fvc_func_e;

  typedef enum logic [1:0] {
    CLS_OUTSIDE   = 2'd0,
    CLS_INTERSECT = 2'd1,
    CLS_INSIDE    = 2'd2
  } fvc_class_e;

  typedef struct packed {
    logic signed [11:0] nx;
    logic signed [11:0] ny;
    logic signed [11:0] nz;
    logic signed [27:0] offset;
  } fvc_plane_t;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic [22:0]        radius;
    logic [22:0]        half_x;
    logic [22:0]        half_y;
    logic [22:0]        half_z;
  } fvc_in_t;

  typedef struct packed {
    logic               hit;
    logic [1:0]         sphere_class;
    logic signed [23:0] near_x;
    logic signed [23:0] near_y;
    logic signed [23:0] near_z;
  } fvc_out_t;

  // item as it travels down the chain
  typedef struct packed {
    fvc_in_t            item;
    logic signed [23:0] r_x;
    logic signed [23:0] r_y;
    logic signed [23:0] r_z;
    logic               pt_fail;
    logic               box_fail;
    logic               sph_out;
    logic               sph_inter;
  } fvc_tok_t;

  // q1.10 times 8-fraction value, floored back to 8 fraction bits
  function automatic logic signed [25:0] mul_floor(logic signed [11:0] n,
                                                   logic signed [23:0] v);
    logic signed [35:0] prod;
    prod = 36'(n) * 36'(v);
    return prod[35:10];
  endfunction

  function automatic logic [24:0] reach_term(logic [22:0] h, logic signed [11:0] n);
    logic [11:0] an;
    logic [34:0] prod;
    an   = n[11] ? 12'(-n) : 12'(n);
    prod = 35'(h) * 35'(an);
    return prod[34:10];
  endfunction

endpackage

### hdl/fvc_cell.sv
// ----------------------------------------------------------------------------
// fvc_cell
// one plane of the chain: plane distances, then clamp step and flag update
// ----------------------------------------------------------------------------
module fvc_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  fvc_pkg::fvc_plane_t plane_i,
  input  logic             valid_i,
  input  fvc_pkg::fvc_tok_t tok_i,
  output logic             valid_o,
  output fvc_pkg::fvc_tok_t tok_o
);
  import fvc_pkg::*;

  logic signed [28:0] er_d, ep_d;
  logic [26:0]        reach_d;
  logic               a_vld_q;
  fvc_tok_t           a_tok_q;
  logic signed [28:0] a_er_q, a_ep_q;
  logic [26:0]        a_reach_q;
  logic               b_vld_q;
  fvc_tok_t           b_tok_q, b_tok_d;

  // stage a: plane distance of the clamped point and of the original point, and the box reach
  assign er_d = 29'(mul_floor(plane_i.nx, tok_i.r_x)) + 29'(mul_floor(plane_i.ny, tok_i.r_y))
              + 29'(mul_floor(plane_i.nz, tok_i.r_z)) - 29'(plane_i.offset);
  assign ep_d = 29'(mul_floor(plane_i.nx, tok_i.item.pos_x))
              + 29'(mul_floor(plane_i.ny, tok_i.item.pos_y))
              + 29'(mul_floor(plane_i.nz, tok_i.item.pos_z)) - 29'(plane_i.offset);
  assign reach_d = 27'(reach_term(tok_i.item.half_x, plane_i.nx))
                 + 27'(reach_term(tok_i.item.half_y, plane_i.ny))
                 + 27'(reach_term(tok_i.item.half_z, plane_i.nz));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else if (adv_i) begin
      a_vld_q <= valid_i;
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_tok_q   <= tok_i;
      a_er_q    <= er_d;
      a_ep_q    <= ep_d;
      a_reach_q <= reach_d;
      b_tok_q   <= b_tok_d;
    end
  end

  function automatic logic signed [23:0] clamp_step(logic signed [23:0] r,
                                                     logic signed [11:0] n,
                                                     logic signed [28:0] e);
    logic signed [40:0] prod;
    logic signed [31:0] diff;
    prod = 41'(n) * 41'(e);
    diff = 32'(r) - 32'($signed(prod[40:10]));
    if (diff > 32'sd8388607) return 24'sh7FFFFF;
    if (diff < -32'sd8388608) return 24'sh800000;
    return diff[23:0];
  endfunction

  // stage b: pull the point onto the plane when outside, collect test flags
  logic signed [29:0] rad_s, ep_abs;
  always_comb begin
    rad_s   = $signed({7'd0, a_tok_q.item.radius});
    ep_abs  = a_ep_q[28] ? -30'(a_ep_q) : 30'(a_ep_q);
    b_tok_d = a_tok_q;
    if (a_er_q < 0) begin
      b_tok_d.r_x = clamp_step(a_tok_q.r_x, plane_i.nx, a_er_q);
      b_tok_d.r_y = clamp_step(a_tok_q.r_y, plane_i.ny, a_er_q);
      b_tok_d.r_z = clamp_step(a_tok_q.r_z, plane_i.nz, a_er_q);
    end
    b_tok_d.pt_fail   = a_tok_q.pt_fail | (a_ep_q < 0);
    b_tok_d.sph_out   = a_tok_q.sph_out | (30'(a_ep_q) < -rad_s);
    b_tok_d.sph_inter = a_tok_q.sph_inter | (ep_abs < rad_s);
    b_tok_d.box_fail  = a_tok_q.box_fail
                      | (-30'(a_ep_q) > $signed({3'd0, a_reach_q}));
  end

  assign valid_o = b_vld_q;
  assign tok_o   = b_tok_q;

endmodule

### hdl/fvc_fin.sv
// ----------------------------------------------------------------------------
// fvc_fin
// squared distance stage and result formatting into the output register
// ----------------------------------------------------------------------------
module fvc_fin (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             valid_i,
  input  fvc_pkg::fvc_tok_t tok_i,
  output logic             valid_o,
  output fvc_pkg::fvc_out_t data_o
);
  import fvc_pkg::*;

  logic signed [24:0] dx, dy, dz;
  logic               s_vld_q, o_vld_q;
  fvc_tok_t           s_tok_q;
  logic [49:0]        sq_x_q, sq_y_q, sq_z_q;
  logic [45:0]        rad2_q;
  logic [51:0]        sum;
  fvc_out_t           o_d, o_q;

  assign dx = 25'(tok_i.item.pos_x) - 25'(tok_i.r_x);
  assign dy = 25'(tok_i.item.pos_y) - 25'(tok_i.r_y);
  assign dz = 25'(tok_i.item.pos_z) - 25'(tok_i.r_z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else if (adv_i) begin
      s_vld_q <= valid_i;
      o_vld_q <= s_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s_tok_q <= tok_i;
      sq_x_q  <= 50'(dx * dx);
      sq_y_q  <= 50'(dy * dy);
      sq_z_q  <= 50'(dz * dz);
      rad2_q  <= 46'(tok_i.item.radius) * 46'(tok_i.item.radius);
      o_q     <= o_d;
    end
  end

  assign sum = 52'(sq_x_q) + 52'(sq_y_q) + 52'(sq_z_q);

  always_comb begin
    o_d = '0;
    case (fvc_func_e'(s_tok_q.item.func))
      FUNC_POINT: begin
        o_d.hit    = ~s_tok_q.pt_fail;
        o_d.near_x = s_tok_q.r_x;
        o_d.near_y = s_tok_q.r_y;
        o_d.near_z = s_tok_q.r_z;
      end
      FUNC_SPHERE_HIT: begin
        o_d.hit    = sum < 52'(rad2_q);
        o_d.near_x = s_tok_q.r_x;
        o_d.near_y = s_tok_q.r_y;
        o_d.near_z = s_tok_q.r_z;
      end
      FUNC_SPHERE_CLASS: begin
        if (s_tok_q.sph_out) o_d.sphere_class = CLS_OUTSIDE;
        else if (s_tok_q.sph_inter) o_d.sphere_class = CLS_INTERSECT;
        else o_d.sphere_class = CLS_INSIDE;
        o_d.hit = ~s_tok_q.sph_out;
      end
      default: o_d.hit = ~s_tok_q.box_fail;
    endcase
  end

  assign valid_o = o_vld_q;
  assign data_o  = o_q;

endmodule

### hdl/frustum_volume_cull_top.sv
// ----------------------------------------------------------------------------
// frustum_volume_cull_top
// six-plane frustum test of points, spheres and boxes, one cell per plane
// ----------------------------------------------------------------------------
// channel  dir  handshake                 content
// in       in   in_valid_i / in_ready_o   func, position, radius, half size
// out      out  out_valid_o / out_ready_i hit, sphere class, closest point
// cfg      in   cfg_valid_i / cfg_ready_o plane register index and data
//
// one transaction per cycle sustained while results are taken; 14 register
// stages (two per plane cell, two in the squared distance and output stage)
// the whole chain advances together; it holds only while the output register
// is full and not taken, and a new transaction is accepted in that same cycle
// the output frees
// reset loads the default planes and empties the chain; cfg always ready
// ----------------------------------------------------------------------------
module frustum_volume_cull_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  fvc_pkg::fvc_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output fvc_pkg::fvc_out_t               out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fvc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [fvc_pkg::CfgDataW-1:0]    cfg_data_i
);
  import fvc_pkg::*;

  logic [CfgDataW-1:0] planes_q [NumPlanes];
  logic                adv;

  // plane registers, out-of-range indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      planes_q <= PlaneReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_LEFT, CFG_RIGHT, CFG_TOP, CFG_BOTTOM, CFG_NEAR, CFG_FAR: begin
          planes_q[cfg_index_i] <= cfg_data_i;
        end
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // chain moves whenever the output register can take a new result
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // clamp order of the closest-point walk: left, top, right, bottom, near, far
  localparam logic [CfgIdxW-1:0] Order [NumPlanes] = '{
    CFG_LEFT, CFG_TOP, CFG_RIGHT, CFG_BOTTOM, CFG_NEAR, CFG_FAR
  };

  logic     vld [NumPlanes+1];
  fvc_tok_t tok [NumPlanes+1];

  always_comb begin
    tok[0]           = '0;
    tok[0].item      = in_data_i;
    tok[0].r_x       = in_data_i.pos_x;
    tok[0].r_y       = in_data_i.pos_y;
    tok[0].r_z       = in_data_i.pos_z;
    vld[0]           = in_valid_i;
  end

  for (genvar k = 0; k < NumPlanes; k++) begin : g_cell
    fvc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .plane_i (fvc_plane_t'(planes_q[Order[k]])),
      .valid_i (vld[k]),
      .tok_i   (tok[k]),
      .valid_o (vld[k+1]),
      .tok_o   (tok[k+1])
    );
  end

  fvc_fin u_fin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (vld[NumPlanes]),
    .tok_i   (tok[NumPlanes]),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

  // a sphere class other than outside always comes with a hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.sphere_class != CLS_OUTSIDE) |-> out_data_o.hit)
    else $error("class without hit");

  // class code three is never produced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.sphere_class != 2'd3))
    else $error("bad sphere class");

  // a sphere classed as intersecting or inside never carries a closest point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.sphere_class != CLS_OUTSIDE) |->
      (out_data_o.near_x == '0 && out_data_o.near_y == '0 && out_data_o.near_z == '0))
    else $error("classified sphere carries a point");

endmodule

### test/frustum_volume_cull_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frustum_volume_cull_top_tb
// checks point, sphere and box culling against six planes: a behavioral
// predictor computes each result on input acceptance, a monitor compares the
// outputs in order, and plane settings change between phases
// ----------------------------------------------------------------------------
module frustum_volume_cull_top_tb;
  import fvc_pkg::*;

  localparam int unsigned ClkHalf    = 6;
  localparam int unsigned DrainWait  = 30;     // margin after the last result
  localparam int unsigned CycleLimit = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  fvc_in_t     in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  fvc_out_t    out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // predictor copy of the plane registers
  logic [CfgDataW-1:0] plane_regs [NumPlanes];
  // results still owed by the block, oldest first
  fvc_out_t    cull_results_q [$];
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  int unsigned burst_left;
  int unsigned stall_mode;
  int unsigned hold_cycles;

  frustum_volume_cull_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // clock and a cycle count that ends a hung run
  initial begin
    clk_i     = 1'b0;
    cycle_cnt = 0;
    forever begin
      #(ClkHalf) clk_i = ~clk_i;
      if (clk_i) begin
        cycle_cnt++;
        if (cycle_cnt > CycleLimit) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------- predictor

  // q1.10 times 8-fraction value, floored; arithmetic shift floors
  function automatic longint fix_mul(longint n, longint v);
    return (n * v) >>> 10;
  endfunction

  function automatic longint norm_of(int k, int axis);
    case (axis)
      0:       return longint'($signed(plane_regs[k][63:52]));
      1:       return longint'($signed(plane_regs[k][51:40]));
      default: return longint'($signed(plane_regs[k][39:28]));
    endcase
  endfunction

  function automatic longint dist_of(int k);
    return longint'($signed(plane_regs[k][27:0]));
  endfunction

  function automatic longint plane_dot(int k, longint v [3]);
    return fix_mul(norm_of(k, 0), v[0]) + fix_mul(norm_of(k, 1), v[1]) +
           fix_mul(norm_of(k, 2), v[2]);
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > 64'sd8388607)  return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic fvc_out_t predict_cull(fvc_in_t it);
    fvc_out_t res;
    longint   p [3];
    longint   r [3];
    longint   hs [3];
    longint   e, a, rad, sq, reach, an;
    int       k, i, pl;
    // closest-point clamp order: left, top, right, bottom, near, far
    int       clamp_order [6];
    fvc_func_e fn;
    clamp_order = '{0, 2, 1, 3, 4, 5};
    fn   = fvc_func_e'(it.func);
    p[0] = longint'(it.pos_x);
    p[1] = longint'(it.pos_y);
    p[2] = longint'(it.pos_z);
    hs[0] = longint'(it.half_x);
    hs[1] = longint'(it.half_y);
    hs[2] = longint'(it.half_z);
    rad  = longint'(it.radius);
    r    = '{0, 0, 0};
    res  = '0;
    if (fn == FUNC_POINT || fn == FUNC_SPHERE_HIT) begin
      r = p;
      for (k = 0; k < 6; k++) begin
        pl = clamp_order[k];
        e  = plane_dot(pl, r) - dist_of(pl);
        if (e < 0) begin
          for (i = 0; i < 3; i++) r[i] = clamp_coord(r[i] - fix_mul(norm_of(pl, i), e));
        end
      end
    end
    case (fn)
      FUNC_POINT: begin
        res.hit = 1'b1;
        for (k = 0; k < 6; k++) if (plane_dot(k, p) < dist_of(k)) res.hit = 1'b0;
      end
      FUNC_SPHERE_HIT: begin
        sq = 0;
        for (i = 0; i < 3; i++) sq += (p[i] - r[i]) * (p[i] - r[i]);
        res.hit = (sq < rad * rad);
      end
      FUNC_SPHERE_CLASS: begin
        res.sphere_class = CLS_INSIDE;
        for (k = 0; k < 6; k++) begin
          e = plane_dot(k, p) - dist_of(k);
          a = (e < 0) ? -e : e;
          if (e < -rad) begin
            res.sphere_class = CLS_OUTSIDE;
            break;
          end
          if (a < rad) res.sphere_class = CLS_INTERSECT;
        end
        res.hit = (res.sphere_class != CLS_OUTSIDE);
      end
      default: begin
        res.hit = 1'b1;
        for (k = 0; k < 6; k++) begin
          reach = 0;
          for (i = 0; i < 3; i++) begin
            an = norm_of(k, i);
            if (an < 0) an = -an;
            reach += fix_mul(hs[i], an);
          end
          if (dist_of(k) - plane_dot(k, p) > reach) begin
            res.hit = 1'b0;
            break;
          end
        end
      end
    endcase
    res.near_x = r[0][23:0];
    res.near_y = r[1][23:0];
    res.near_z = r[2][23:0];
    return res;
  endfunction

  // ------------------------------------------------------------------ monitor

  // register writes and accepted inputs feed the predictor, outputs are checked
  always @(posedge clk_i or negedge rst_ni) begin
    fvc_out_t want;
    if (!rst_ni) begin
      for (int k = 0; k < NumPlanes; k++) plane_regs[k] = PlaneReset[k];
      cull_results_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o && cfg_index_i < NumPlanes)
        plane_regs[cfg_index_i] = cfg_data_i;
      if (in_valid_i && in_ready_o)
        cull_results_q.push_back(predict_cull(in_data_i));
      if (out_valid_o && out_ready_i) begin
        if (cull_results_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("unexpected result transaction %p", out_data_o);
        end else begin
          want = cull_results_q.pop_front();
          if (out_data_o.hit !== want.hit || out_data_o.sphere_class !== want.sphere_class ||
              out_data_o.near_x !== want.near_x || out_data_o.near_y !== want.near_y ||
              out_data_o.near_z !== want.near_z) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: expected hit %0b cls %0d near %0d %0d %0d, got hit %0b cls %0d near %0d %0d %0d",
                       want.hit, want.sphere_class, want.near_x, want.near_y, want.near_z,
                       out_data_o.hit, out_data_o.sphere_class, out_data_o.near_x,
                       out_data_o.near_y, out_data_o.near_z);
          end
        end
      end
    end
  end

  // receiver: stall pattern is redrawn at random periodically; a long hold overrides it
  initial begin
    out_ready_i = 1'b0;
    stall_mode  = 0;
    hold_cycles = 0;
    forever begin
      @(posedge clk_i);
      if (cycle_cnt % 64 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        hold_cycles--;
      end else begin
        case (stall_mode)
          0:       out_ready_i <= 1'b1;                          // no stalls
          1:       out_ready_i <= ($urandom_range(0, 3) != 0);
          2:       out_ready_i <= ($urandom_range(0, 9) < 3);
          default: out_ready_i <= (cycle_cnt % 5 < 3);
        endcase
      end
    end
  end

  // ------------------------------------------------------------------- sender

  // offer one transaction; gaps fall between bursts of random length
  task automatic send_item(input fvc_in_t it);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 6);
      burst_left = $urandom_range(0, 24);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // drop valid and let the chain empty
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (cull_results_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_plane(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [CfgDataW-1:0] pack_plane(int nx, int ny, int nz, int d);
    return {12'(nx), 12'(ny), 12'(nz), 28'(d)};
  endfunction

  function automatic fvc_in_t make_item(fvc_func_e fn, int x, int y, int z,
                                        int rad, int hx, int hy, int hz);
    fvc_in_t it;
    it.func   = fn;
    it.pos_x  = 24'(x);
    it.pos_y  = 24'(y);
    it.pos_z  = 24'(z);
    it.radius = 23'(rad);
    it.half_x = 23'(hx);
    it.half_y = 23'(hy);
    it.half_z = 23'(hz);
    return it;
  endfunction

  // mostly values near the frustum, sometimes the full field range
  function automatic int pick_coord();
    if ($urandom_range(0, 9) < 7) return int'($urandom_range(0, 8191)) - 4096;
    return int'($signed(24'($urandom)));
  endfunction

  function automatic int pick_size();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 4096);
    return int'($urandom & 32'h7FFFFF);
  endfunction

  task automatic send_random(input int unsigned count);
    repeat (count)
      send_item(make_item(fvc_func_e'($urandom_range(0, 3)), pick_coord(), pick_coord(),
                          pick_coord(), pick_size(), pick_size(), pick_size(), pick_size()));
  endtask

  // ------------------------------------------------------------------- tests

  // field extremes, every func, points on a plane and tangent spheres
  task automatic test_directed();
    send_item(make_item(FUNC_POINT, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(FUNC_POINT, 8388607, 8388607, 8388607, 0, 0, 0, 0));
    send_item(make_item(FUNC_POINT, -8388608, -8388608, -8388608, 0, 0, 0, 0));
    send_item(make_item(FUNC_POINT, 256, -256, 512, 0, 0, 0, 0));
    send_item(make_item(FUNC_SPHERE_HIT, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(FUNC_SPHERE_HIT, 300, 0, 0, 300, 0, 0, 0));    // tangent, no hit
    send_item(make_item(FUNC_SPHERE_HIT, 300, 0, 0, 301, 0, 0, 0));
    send_item(make_item(FUNC_SPHERE_HIT, 8388607, -8388608, 8388607, 8388607, 0, 0, 0));
    send_item(make_item(FUNC_SPHERE_HIT, -8388608, 8388607, -8388608, 0, 8388607, 8388607,
                        8388607));
    send_item(make_item(FUNC_SPHERE_CLASS, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(FUNC_SPHERE_CLASS, 0, 0, 0, 8388607, 0, 0, 0));
    send_item(make_item(FUNC_SPHERE_CLASS, -512, 0, 0, 512, 0, 0, 0)); // touching from outside
    send_item(make_item(FUNC_SPHERE_CLASS, -513, 0, 0, 512, 0, 0, 0));
    send_item(make_item(FUNC_SPHERE_CLASS, 8388607, 8388607, -8388608, 8388607, 0, 0, 0));
    send_item(make_item(FUNC_BOX, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(FUNC_BOX, 1024, 0, 0, 0, 1024, 0, 0));         // face on the plane
    send_item(make_item(FUNC_BOX, 1025, 0, 0, 0, 1024, 0, 0));
    send_item(make_item(FUNC_BOX, -8388608, -8388608, -8388608, 0, 8388607, 8388607, 8388607));
    send_item(make_item(FUNC_BOX, 8388607, 8388607, 8388607, 8388607, 0, 0, 0));
    wait_idle();
  endtask

  // a 20-unit cube around the origin, within the range where most random coordinates are drawn
  task automatic test_cube_frustum();
    write_plane(CFG_LEFT,   pack_plane(1024, 0, 0, -2560));
    write_plane(CFG_RIGHT,  pack_plane(-1024, 0, 0, -2560));
    write_plane(CFG_TOP,    pack_plane(0, -1024, 0, -2560));
    write_plane(CFG_BOTTOM, pack_plane(0, 1024, 0, -2560));
    write_plane(CFG_NEAR,   pack_plane(0, 0, 1024, -2560));
    write_plane(CFG_FAR,    pack_plane(0, 0, -1024, -2560));
    send_random(300);
    wait_idle();
  endtask

  // tilted planes with random normals and offsets
  task automatic test_random_planes();
    for (int k = 0; k < NumPlanes; k++)
      write_plane(CfgIdxW'(k), pack_plane(int'($urandom_range(0, 4095)) - 2048,
                                          int'($urandom_range(0, 4095)) - 2048,
                                          int'($urandom_range(0, 4095)) - 2048,
                                          -int'($urandom_range(0, 8191))));
    send_random(200);
    wait_idle();
  endtask

  // register field extremes, plus writes to unused indexes that must be ignored, then random words
  task automatic test_extreme_planes();
    write_plane(CFG_LEFT,   {CfgDataW{1'b1}});
    write_plane(CFG_RIGHT,  '0);
    write_plane(CFG_TOP,    64'h7FF7_FF7F_F7FF_FFFF);
    write_plane(CFG_BOTTOM, 64'h8008_0080_0800_0000);
    write_plane(CFG_NEAR,   64'h7FF8_007F_F800_0000);
    write_plane(CFG_FAR,    64'h8007_FF80_07FF_FFFF);
    write_plane(CfgIdxW'(6), 64'h5555_5555_5555_5555);
    write_plane(CfgIdxW'(7), 64'hAAAA_AAAA_AAAA_AAAA);
    send_random(200);
    wait_idle();
    for (int k = 0; k < NumPlanes; k++) write_plane(CfgIdxW'(k), {$urandom, $urandom});
    send_random(150);
    wait_idle();
  endtask

  // long receiver hold while transactions keep coming, so the input stalls
  task automatic test_backpressure();
    for (int k = 0; k < NumPlanes; k++) write_plane(CfgIdxW'(k), PlaneReset[k]);
    hold_cycles = 400;
    send_random(60);
    send_random(240);
    wait_idle();
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    mismatch_cnt = 0;
    burst_left   = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_cube_frustum();
    test_random_planes();
    test_extreme_planes();
    test_backpressure();

    if (mismatch_cnt == 0 && cull_results_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
hdl/fvc_pkg.sv
hdl/fvc_cell.sv
hdl/fvc_fin.sv
hdl/frustum_volume_cull_top.sv
test/frustum_volume_cull_top_tb.sv
